// ===== hdl/grouped_free_block_allocator_macros.svh =====
// ----------------------------------------------------------------------------
// grouped free block allocator assertion macros
// shared clocking and reset gating for the concurrent checks
// ----------------------------------------------------------------------------
`ifndef GROUPED_FREE_BLOCK_ALLOCATOR_MACROS_SVH
`define GROUPED_FREE_BLOCK_ALLOCATOR_MACROS_SVH

// property that must hold in the same cycle as its condition
`define GFBA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// property that must hold in the cycle after its condition
`define GFBA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/gfba_pkg.sv =====
// ----------------------------------------------------------------------------
// gfba_pkg
// types and constants shared by the grouped free block allocator
// ----------------------------------------------------------------------------
`default_nettype none

package gfba_pkg;

    localparam int BLK_W       = 10;
    localparam int CNT_W       = 11;
    localparam int BLOCK_COUNT = 1024;
    localparam int GROUP_DEF   = 16;

    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 24;

    localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(BLOCK_COUNT);

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // result item bit positions inside m_tdata
    localparam int OUT_FULL_BIT = BLK_W;
    localparam int OUT_CNT_LSB  = BLK_W + 1;
    localparam int OUT_MOD_BIT  = BLK_W + 1 + CNT_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_POP,
        ST_REFILL,
        ST_SPILL,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

// ===== hdl/gfba_group_mem.sv =====
// ----------------------------------------------------------------------------
// gfba_group_mem
// group store: one group of free block numbers per block, one word per
// cycle, registered read, zero fill sweep after reset
// ----------------------------------------------------------------------------
`default_nettype none

module gfba_group_mem
    import gfba_pkg::*;
#(
    parameter int GROUP = GROUP_DEF
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_we,
    input  wire [BLK_W+$clog2(GROUP)-1:0]   i_waddr,
    input  wire [BLK_W-1:0]                 i_wdata,
    input  wire [BLK_W+$clog2(GROUP)-1:0]   i_raddr,
    output logic [BLK_W-1:0]                o_rdata,
    output logic                            o_busy
);

    localparam int IW    = $clog2(GROUP);
    localparam int AW    = BLK_W + IW;
    localparam int DEPTH = BLOCK_COUNT << IW;

    logic [BLK_W-1:0] r_mem [DEPTH];
    logic [BLK_W-1:0] r_rdata;
    logic [AW-1:0]    r_clr_addr;
    logic             r_busy;

    // zero sweep over every word, one per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (&r_clr_addr) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_busy;

endmodule

`default_nettype wire

// ===== hdl/grouped_free_block_allocator.sv =====
// ----------------------------------------------------------------------------
// grouped_free_block_allocator
// chained free list allocator: a stack of GROUP free block numbers whose
// bottom entry links to the next group held in the group store
// ----------------------------------------------------------------------------
// Each item on the input stream is an allocate (s_tuser = 0) or a free of
// the block in s_tdata (s_tuser = 1); each gives one result item. A plain
// free or a failed allocate goes from ST_EXEC to ST_DONE, where its result
// is loaded into the output register; a plain allocate goes through
// ST_EXEC, ST_POP and ST_DONE. An allocate that pops the link block then
// refills the stack in ST_REFILL, and a free into a full stack spills it
// in ST_SPILL; both copy one word per cycle between the stack memory and
// the group store. After reset the group store is swept to zero over all
// BLOCK_COUNT * 2**ceil(log2(GROUP)) words (16384 at the defaults), and
// s_tready stays low until the sweep is done. A new item is taken while
// the previous result still waits in the output register; the next
// result then waits for m_tready before another item is taken.
`default_nettype none

module grouped_free_block_allocator
    import gfba_pkg::*;
#(
    parameter int GROUP = GROUP_DEF
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     s_tvalid,
    output logic                    s_tready,
    input  wire [IN_DATA_W-1:0]     s_tdata,    // block_number[9:0], zero [15:10]
    input  wire                     s_tuser,    // kind
    output logic                    m_tvalid,
    input  wire                     m_tready,
    output logic [OUT_DATA_W-1:0]   m_tdata     // allocated_block[9:0], disk_full[10],
                                                // free_blocks[21:11], list_modified[22],
                                                // zero [23]
);

    localparam int SPW = $clog2(GROUP + 1);
    localparam int IW  = $clog2(GROUP);
    localparam int AW  = BLK_W + IW;

    localparam logic [SPW-1:0] GROUP_SP = SPW'(GROUP);
    localparam logic [SPW-1:0] LINK_SP  = SPW'(GROUP - 1);
    localparam logic [IW-1:0]  IDX_LAST = IW'(GROUP - 1);

    t_state r_state, n_state;

    logic [SPW-1:0]        r_sp;
    logic [CNT_W-1:0]      r_count;
    logic                  r_mod;
    logic                  r_kind;
    logic [BLK_W-1:0]      r_blk;
    logic [BLK_W-1:0]      r_got;
    logic                  r_full;
    logic [IW-1:0]         r_idx;
    logic                  r_m_valid;
    logic [OUT_DATA_W-1:0] r_m_data;

    // stack memory
    logic [BLK_W-1:0] r_stk [GROUP];
    logic [BLK_W-1:0] r_stk_rdata;
    logic             stk_we;
    logic [IW-1:0]    stk_waddr;
    logic [BLK_W-1:0] stk_wdata;
    logic [IW-1:0]    stk_raddr;

    // group store port
    logic             grp_we;
    logic [AW-1:0]    grp_waddr;
    logic [BLK_W-1:0] grp_wdata;
    logic [AW-1:0]    grp_raddr;
    logic [BLK_W-1:0] grp_rdata;
    logic             grp_busy;

    logic             in_accept;
    logic             out_load;
    logic             alloc_none;
    logic             sp_empty;
    logic             idx_last;
    logic [IW-1:0]    idx_next;
    logic [IW-1:0]    sp_idx;
    logic [SPW-1:0]   sp_dec;
    logic [CNT_W-1:0] count_inc;

    gfba_group_mem #(
        .GROUP(GROUP)
    ) u_group_mem (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_we   (grp_we),
        .i_waddr(grp_waddr),
        .i_wdata(grp_wdata),
        .i_raddr(grp_raddr),
        .o_rdata(grp_rdata),
        .o_busy (grp_busy)
    );

    assign in_accept  = s_tvalid && s_tready;
    assign out_load   = (r_state == ST_DONE) && (!r_m_valid || m_tready);
    assign alloc_none = (r_count == '0) || (r_sp >= GROUP_SP);
    assign sp_empty   = (r_sp == '0);
    assign idx_last   = (r_idx == IDX_LAST);
    assign idx_next   = idx_last ? '0 : r_idx + IW'(1);
    assign sp_idx     = (r_sp >= GROUP_SP) ? '0 : r_sp[IW-1:0];
    assign sp_dec     = r_sp - SPW'(1);
    // double frees hold the count at the block total
    assign count_inc  = (r_count == COUNT_MAX) ? r_count : r_count + CNT_W'(1);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (r_kind == KIND_ALLOC) begin
                    n_state = alloc_none ? ST_DONE : ST_POP;
                end else begin
                    n_state = sp_empty ? ST_SPILL : ST_DONE;
                end
            end
            ST_POP: begin
                n_state = (r_sp == LINK_SP) ? ST_REFILL : ST_DONE;
            end
            ST_REFILL: begin
                if (idx_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_SPILL: begin
                if (idx_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready  = 1'b0;
        stk_we    = 1'b0;
        stk_waddr = sp_dec[IW-1:0];
        stk_wdata = r_blk;
        stk_raddr = sp_idx;
        grp_we    = 1'b0;
        grp_waddr = {r_blk, r_idx};
        grp_wdata = r_stk_rdata;
        grp_raddr = {r_got, idx_next};
        case (r_state)
            ST_IDLE: begin
                s_tready = !grp_busy;
            end
            ST_EXEC: begin
                // push without spill
                stk_we = (r_kind == KIND_FREE) && !sp_empty;
            end
            ST_POP: begin
                // first word of the link block's group
                grp_raddr = {r_stk_rdata, IW'(0)};
            end
            ST_REFILL: begin
                stk_we    = 1'b1;
                stk_waddr = r_idx;
                stk_wdata = grp_rdata;
            end
            ST_SPILL: begin
                grp_we    = 1'b1;
                stk_raddr = idx_next;
                // freed block becomes the new link once the stack is saved
                if (idx_last) begin
                    stk_we    = 1'b1;
                    stk_waddr = IDX_LAST;
                end
            end
            ST_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stk[stk_waddr] <= stk_wdata;
        end
        r_stk_rdata <= r_stk[stk_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_sp      <= GROUP_SP;
            r_count   <= '0;
            r_mod     <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_m_valid <= 1'b1;
            end else if (m_tready) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                ST_EXEC: begin
                    if ((r_kind == KIND_FREE) && !sp_empty) begin
                        r_sp    <= sp_dec;
                        r_count <= count_inc;
                        r_mod   <= 1'b1;
                    end
                end
                ST_POP: begin
                    r_count <= r_count - CNT_W'(1);
                    r_mod   <= 1'b1;
                    if (r_sp != LINK_SP) begin
                        r_sp <= r_sp + SPW'(1);
                    end
                end
                ST_REFILL: begin
                    if (idx_last) begin
                        r_sp <= '0;
                    end
                end
                ST_SPILL: begin
                    if (idx_last) begin
                        r_sp    <= LINK_SP;
                        r_count <= count_inc;
                        r_mod   <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    r_kind <= s_tuser;
                    r_blk  <= s_tdata[BLK_W-1:0];
                end
            end
            ST_EXEC: begin
                r_got  <= '0;
                r_full <= (r_kind == KIND_ALLOC) && alloc_none;
                r_idx  <= '0;
            end
            ST_POP: begin
                r_got <= r_stk_rdata;
                r_idx <= '0;
            end
            ST_REFILL: begin
                r_idx <= idx_next;
            end
            ST_SPILL: begin
                r_idx <= idx_next;
            end
            ST_DONE: begin
                if (out_load) begin
                    r_m_data <= {1'b0, r_mod, r_count, r_full, r_got};
                end
            end
            default: begin
            end
        endcase
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = r_m_data;

    `include "grouped_free_block_allocator_macros.svh"

    `GFBA_ASSERT_NOW(a_sp_range, 1'b1, r_sp <= GROUP_SP, "stack pointer beyond group size")
    `GFBA_ASSERT_NOW(a_count_range, 1'b1, r_count <= COUNT_MAX, "free count beyond block total")
    `GFBA_ASSERT_NOW(a_no_take_in_sweep, grp_busy, !s_tready, "item taken during store sweep")
    `GFBA_ASSERT_NEXT(a_refill_end, (r_state == ST_REFILL) && idx_last, r_sp == '0, "refill did not reset stack pointer")
    `GFBA_ASSERT_NEXT(a_spill_end, (r_state == ST_SPILL) && idx_last, r_sp == LINK_SP, "spill did not leave link on stack")
    `GFBA_ASSERT_NOW(a_full_zero, r_m_valid && r_m_data[OUT_FULL_BIT], r_m_data[BLK_W-1:0] == '0, "full result carries a block")

endmodule

`default_nettype wire
